/* rtl/dspbt_pkg.sv */
`default_nettype none

package dspbt_pkg;

  // Field widths of the channels.
  localparam int unsigned NODE_W   = 6;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned DIST_W   = 40;

  // Only the low WEIGHT_BITS bits of an edge weight take part in the sum.
  localparam int unsigned WEIGHT_BITS = 32;
  localparam int unsigned WGT_USE     = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

  localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

  localparam int unsigned MAX_NODES_DEF = 64;

  // Item function codes.
  localparam logic FUNC_EDGE   = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  // Outcome of one edge relaxation.
  typedef struct packed {
    logic [DIST_W-1:0] cand;
    logic              better;
  } relax_res_t;

endpackage

`default_nettype wire

/* rtl/dspbt_in_if.sv */
`default_nettype none

interface dspbt_in_if import dspbt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [NODE_W-1:0]   from_node;
  logic [NODE_W-1:0]   to_node;
  logic [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, func, from_node, to_node, edge_weight, input ready);
  modport sink   (input valid, func, from_node, to_node, edge_weight, output ready);
endinterface

`default_nettype wire

/* rtl/dspbt_out_if.sv */
`default_nettype none

interface dspbt_out_if import dspbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] node_index;
  logic [DIST_W-1:0] path_weight;
  logic              unreachable;
  logic              last;

  modport source (output valid, node_index, path_weight, unreachable, last, input ready);
  modport sink   (input valid, node_index, path_weight, unreachable, last, output ready);
endinterface

`default_nettype wire

/* rtl/dspbt_relax.sv */
`default_nettype none

module dspbt_relax import dspbt_pkg::*; (
  input  logic [DIST_W-1:0]  dist_src,
  input  logic [DIST_W-1:0]  dist_dst,
  input  logic [WGT_USE-1:0] weight,
  output relax_res_t         res
);

  logic [DIST_W:0] sum;

  // A carry out of the distance width means the sum is past all ones.
  assign sum = {1'b0, dist_src} + {{(DIST_W + 1 - WGT_USE){1'b0}}, weight};

  always_comb begin
    res.cand   = sum[DIST_W] ? DIST_ONES : sum[DIST_W-1:0];
    res.better = (res.cand < dist_dst);
  end

endmodule

`default_nettype wire

/* rtl/dag_shortest_path_backtrack_core.sv */
`default_nettype none

// Channel   Dir  Handshake     Payload
// in_chan   in   valid/ready   func, from_node, to_node, edge_weight
// out_chan  out  valid/ready   node_index, path_weight, unreachable, last
//
// An edge item is accepted in S_IDLE, which reads both distances from the distance
// memory; S_RUPD then adds, compares and writes back.
// A finish item walks back via S_WREQ and S_WGET for each node above node 0 and S_WREQ
// for node 0, emits via S_EREQ and S_EGET per path node, holding in S_EGET while out_chan
// stalls, then clears. After reset the same clearing pass runs before the first item.
// The last node of a finished result may wait in the output register while the next item is accepted.

module dag_shortest_path_backtrack_core import dspbt_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  dspbt_in_if.sink      in_chan,
  dspbt_out_if.source   out_chan
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = NW + 1;
  localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RUPD = 3'd2;
  localparam logic [2:0] S_WREQ = 3'd3;
  localparam logic [2:0] S_WGET = 3'd4;
  localparam logic [2:0] S_EREQ = 3'd5;
  localparam logic [2:0] S_EGET = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] succ_r, succ_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] remain_r, remain_nxt;
  logic [NW-1:0] clr_idx_r, clr_idx_nxt;
  logic [NW-1:0] high_r, high_nxt;

  // Captured edge.
  logic [NW-1:0]      src_r, dst_r;
  logic [WGT_USE-1:0] wgt_r;
  logic               edge_ok_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_node_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_unr_r;
  logic              out_last_r;
  logic              out_load;

  // Memories.
  logic [DIST_W-1:0] dist_mem [MAX_NODES];
  logic [NW-1:0]     link_mem [MAX_NODES];
  logic [DIST_W-1:0] dist_a_q, dist_b_q;
  logic [NW-1:0]     link_q;

  logic              dist_we, link_we;
  logic [NW-1:0]     dist_waddr, link_waddr;
  logic [DIST_W-1:0] dist_wdata;
  logic [NW-1:0]     link_wdata;
  logic              rd_a_en, rd_b_en, link_re;
  logic [NW-1:0]     rd_a_addr;

  logic              accept;
  logic [NODE_W+NW-1:0] src_ext, dst_ext, cur_ext;
  logic [NW-1:0]     in_src_idx, in_dst_idx;
  logic              in_edge_ok;
  logic              emit_last;
  relax_res_t        relax;

  assign accept  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  assign src_ext    = {{NW{1'b0}}, in_chan.from_node};
  assign dst_ext    = {{NW{1'b0}}, in_chan.to_node};
  assign in_src_idx = src_ext[NW-1:0];
  assign in_dst_idx = dst_ext[NW-1:0];
  assign in_edge_ok = (in_chan.from_node < in_chan.to_node) &&
                      (32'(in_chan.to_node) < MAX_NODES);
  assign cur_ext    = {{NODE_W{1'b0}}, cur_r};

  assign emit_last  = (remain_r == CW'(1));
  assign out_load   = (state_r == S_EGET) && (!out_valid_r || out_chan.ready);

  dspbt_relax u_relax (
    .dist_src (dist_a_q),
    .dist_dst (dist_b_q),
    .weight   (wgt_r),
    .res      (relax)
  );

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    succ_nxt    = succ_r;
    depth_nxt   = depth_r;
    remain_nxt  = remain_r;
    clr_idx_nxt = clr_idx_r;
    high_nxt    = high_r;
    dist_we     = 1'b0;
    dist_waddr  = dst_r;
    dist_wdata  = relax.cand;
    link_we     = 1'b0;
    link_waddr  = dst_r;
    link_wdata  = src_r;
    rd_a_en     = 1'b0;
    rd_a_addr   = cur_r;
    rd_b_en     = 1'b0;
    link_re     = 1'b0;

    unique case (state_r)
      S_CLR: begin
        dist_we    = 1'b1;
        dist_waddr = clr_idx_r;
        dist_wdata = (clr_idx_r == '0) ? '0 : DIST_ONES;
        clr_idx_nxt = clr_idx_r + NW'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_chan.func == FUNC_FINISH) begin
            cur_nxt   = high_r;
            depth_nxt = '0;
            state_nxt = S_WREQ;
          end else begin
            rd_a_en   = 1'b1;
            rd_a_addr = in_src_idx;
            rd_b_en   = 1'b1;
            state_nxt = S_RUPD;
          end
        end
      end
      S_RUPD: begin
        if (edge_ok_r) begin
          dist_we = relax.better;
          link_we = relax.better;
          if (dst_r > high_r) begin
            high_nxt = dst_r;
          end
        end
        state_nxt = S_IDLE;
      end
      S_WREQ: begin
        depth_nxt = depth_r + CW'(1);
        if (cur_r == '0) begin
          // Node 0 ends the walk; it points forward to the node visited before it.
          link_we    = 1'b1;
          link_waddr = '0;
          link_wdata = succ_r;
          remain_nxt = depth_r + CW'(1);
          state_nxt  = S_EREQ;
        end else begin
          rd_a_en   = 1'b1;
          link_re   = 1'b1;
          state_nxt = S_WGET;
        end
      end
      S_WGET: begin
        // Reverse the predecessor link into a successor link as the walk passes.
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = succ_r;
        succ_nxt   = cur_r;
        cur_nxt    = (dist_a_q == DIST_ONES) ? '0 : link_q;
        state_nxt  = S_WREQ;
      end
      S_EREQ: begin
        rd_a_en   = 1'b1;
        link_re   = 1'b1;
        state_nxt = S_EGET;
      end
      S_EGET: begin
        if (out_load) begin
          remain_nxt = remain_r - CW'(1);
          cur_nxt    = link_q;
          if (emit_last) begin
            clr_idx_nxt = '0;
            high_nxt    = '0;
            state_nxt   = S_CLR;
          end else begin
            state_nxt = S_EREQ;
          end
        end
      end
      default: begin
        clr_idx_nxt = '0;
        state_nxt   = S_CLR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      high_r      <= '0;
      depth_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      high_r      <= high_nxt;
      depth_r     <= depth_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    succ_r <= succ_nxt;
    if (accept) begin
      src_r     <= in_src_idx;
      dst_r     <= in_dst_idx;
      wgt_r     <= in_chan.edge_weight[WGT_USE-1:0];
      edge_ok_r <= in_edge_ok;
    end
    if (out_load) begin
      out_node_r <= cur_ext[NODE_W-1:0];
      out_dist_r <= dist_a_q;
      out_unr_r  <= (cur_r != '0) && (dist_a_q == DIST_ONES);
      out_last_r <= emit_last;
    end
  end

  // Distance memory: one write port, two read ports.
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (rd_a_en) begin
      dist_a_q <= dist_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      dist_b_q <= dist_mem[in_dst_idx];
    end
  end

  // Link memory: predecessors, turned into successors during the walk.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_q <= link_mem[cur_r];
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.node_index  = out_node_r;
  assign out_chan.path_weight = out_dist_r;
  assign out_chan.unreachable = out_unr_r;
  assign out_chan.last        = out_last_r;

  // The backward walk always moves to a lower node.
  a_walk_descends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WGET && cur_r != '0 && dist_a_q != DIST_ONES) |-> (link_q < cur_r))
    else $error("backtrack link does not point to a lower node");

  // Emission never runs with an exhausted count.
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EREQ || state_r == S_EGET) |-> (remain_r != '0))
    else $error("emission with no path nodes left");

  // The walk depth stays within the node count.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WREQ) |-> (32'(depth_r) < MAX_NODES))
    else $error("backtrack walk deeper than the node count");

  // The clearing pass ends after its last entry.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && clr_idx_r == LAST_IDX) |=> (state_r == S_IDLE))
    else $error("clearing pass did not finish");

  // The highest node is reset whenever the distances are being cleared.
  a_high_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (high_r == '0))
    else $error("highest node kept across a clear");

endmodule

`default_nettype wire

/* sim/dag_shortest_path_backtrack_core_tb.sv */
module dag_shortest_path_backtrack_core_tb;
  import dspbt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                func;
    logic [NODE_W-1:0]   from_node;
    logic [NODE_W-1:0]   to_node;
    logic [WEIGHT_W-1:0] edge_weight;
  } lattice_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [DIST_W-1:0] path_weight;
    logic              unreachable;
    logic              last;
  } path_node_t;

  // A directed row either relies on the predictor or, for a finish on an empty
  // lattice, expects node 0 alone.
  typedef struct packed {
    lattice_item_t item;
    logic          lone_origin;
  } dir_row_t;

  localparam path_node_t ORIGIN_ONLY = '{node_index: '0, path_weight: '0,
                                         unreachable: 1'b0, last: 1'b1};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = {WEIGHT_W{1'b1}} >> (WEIGHT_W - WGT_USE);
  localparam int unsigned PHASE_QUOTA = 50;

  logic clk;
  logic rst_n;

  dspbt_in_if  in_chan ();
  dspbt_out_if out_chan ();

  dag_shortest_path_backtrack_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [DIST_W-1:0] lat_dist [MAX_NODES_DEF];
  logic [NODE_W-1:0] lat_pred [MAX_NODES_DEF];
  logic [NODE_W-1:0] lat_top;

  path_node_t  expected_path_q [$];
  dir_row_t    directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned lattice_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_lattice();
    for (int i = 0; i < MAX_NODES_DEF; i++) begin
      lat_dist[i] = DIST_ONES;
    end
    lat_dist[0] = '0;
    lat_top     = '0;
  endfunction

  function automatic void queue_expected(path_node_t pn);
    expected_path_q.insert(expected_path_q.size(), pn);
  endfunction

  function automatic void add_directed_row(lattice_item_t it, logic lone);
    dir_row_t row;
    row.item        = it;
    row.lone_origin = lone;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Updates the lattice copy for one accepted item; a finish also queues the
  // path it should produce unless the caller has typed it in already.
  function automatic void apply_to_lattice(lattice_item_t it, bit queue_path);
    logic [DIST_W:0]   sum;
    logic [DIST_W:0]   wext;
    logic [DIST_W-1:0] cand;
    logic [NODE_W-1:0] walk_stack [MAX_NODES_DEF];
    logic [NODE_W-1:0] node;
    int unsigned       depth;
    bit                done;
    path_node_t        pn;
    if (it.func == FUNC_EDGE) begin
      if (it.from_node < it.to_node) begin
        wext = '0;
        wext[WEIGHT_W-1:0] = it.edge_weight & WEIGHT_MASK;
        sum  = {1'b0, lat_dist[it.from_node]} + wext;
        cand = (sum >= {1'b0, DIST_ONES}) ? DIST_ONES : sum[DIST_W-1:0];
        if (cand < lat_dist[it.to_node]) begin
          lat_dist[it.to_node] = cand;
          lat_pred[it.to_node] = it.from_node;
        end
        if (it.to_node > lat_top) begin
          lat_top = it.to_node;
        end
      end
    end else begin
      depth = 0;
      node  = lat_top;
      done  = 1'b0;
      while (!done) begin
        walk_stack[depth] = node;
        depth++;
        if (node == 0 || depth == MAX_NODES_DEF) begin
          done = 1'b1;
        end else if (lat_dist[node] == DIST_ONES) begin
          // An unreachable node jumps straight back to the origin.
          node = '0;
        end else begin
          node = lat_pred[node];
        end
      end
      for (int unsigned k = 0; k < depth; k++) begin
        pn.node_index  = walk_stack[depth - 1 - k];
        pn.path_weight = lat_dist[pn.node_index];
        pn.unreachable = (pn.node_index != 0) && (pn.path_weight == DIST_ONES);
        pn.last        = (k + 1 == depth);
        if (queue_path) begin
          queue_expected(pn);
        end
      end
      clear_lattice();
    end
  endfunction

  function automatic lattice_item_t lattice_item(logic func, int unsigned from_n,
                                                 int unsigned to_n,
                                                 logic [WEIGHT_W-1:0] w);
    lattice_item_t it;
    it.func        = func;
    it.from_node   = from_n[NODE_W-1:0];
    it.to_node     = to_n[NODE_W-1:0];
    it.edge_weight = w;
    return it;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(7))
      0: return '0;
      1: return {WEIGHT_W{1'b1}};
      2: return WEIGHT_W'($urandom_range(3));
      3: return {WEIGHT_W{1'b1}} - WEIGHT_W'($urandom_range(255));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DIST_W-1:0] got,
                                 logic [DIST_W-1:0] want);
    if (mismatch_count < 100) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Called at a rising edge; returns at the edge where the item was accepted.
  task automatic send_lattice_item(lattice_item_t it, bit lone_origin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= it.func;
    in_chan.from_node   <= it.from_node;
    in_chan.to_node     <= it.to_node;
    in_chan.edge_weight <= it.edge_weight;
    do @(posedge clk); while (!in_chan.ready);
    if (lone_origin) begin
      queue_expected(ORIGIN_ONLY);
    end
    apply_to_lattice(it, !lone_origin);
    if (it.func == FUNC_FINISH || it.from_node < it.to_node) begin
      lattice_items++;
    end
  endtask

  // One sentence: edges grouped by ascending target, a little noise, a finish.
  task automatic run_sentence(int unsigned n_nodes, bit chain);
    int unsigned k;
    int unsigned src;
    int unsigned tgt;
    for (int unsigned t = 1; t < n_nodes; t++) begin
      k = chain ? 1 : (($urandom_range(9) < 2) ? 0 : $urandom_range(1, 3));
      for (int unsigned j = 0; j < k; j++) begin
        src = (chain || $urandom_range(3) == 0) ? t - 1 : $urandom_range(0, t - 1);
        send_lattice_item(lattice_item(FUNC_EDGE, src, t, rand_weight()), 1'b0);
      end
      if (!chain && $urandom_range(15) == 0) begin
        tgt = ($urandom_range(1) == 0) ? t : 0;
        send_lattice_item(lattice_item(FUNC_EDGE, $urandom_range(t, 63), tgt,
                                       rand_weight()), 1'b0);
      end
      if (!chain && t >= 2 && $urandom_range(15) == 0) begin
        tgt = $urandom_range(1, t - 1);
        src = $urandom_range(0, tgt - 1);
        send_lattice_item(lattice_item(FUNC_EDGE, src, tgt, rand_weight()), 1'b0);
      end
    end
    send_lattice_item(lattice_item(FUNC_FINISH, $urandom_range(63), $urandom_range(63),
                                   WEIGHT_W'($urandom)), 1'b0);
  endtask

  always @(posedge clk) begin : result_check
    path_node_t want;
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_path_q.size() == 0) begin
        report_mismatch("node_index with no result pending",
                        DIST_W'(out_chan.node_index), '0);
      end else begin
        want = expected_path_q.pop_front();
        if (out_chan.node_index !== want.node_index)
          report_mismatch("node_index", DIST_W'(out_chan.node_index),
                          DIST_W'(want.node_index));
        if (out_chan.path_weight !== want.path_weight)
          report_mismatch("path_weight", out_chan.path_weight, want.path_weight);
        if (out_chan.unreachable !== want.unreachable)
          report_mismatch("unreachable", DIST_W'(out_chan.unreachable),
                          DIST_W'(want.unreachable));
        if (out_chan.last !== want.last)
          report_mismatch("last", DIST_W'(out_chan.last), DIST_W'(want.last));
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL dag_shortest_path_backtrack_core");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.func        <= FUNC_EDGE;
    in_chan.from_node   <= '0;
    in_chan.to_node     <= '0;
    in_chan.edge_weight <= '0;
    for (int i = 0; i < MAX_NODES_DEF; i++) begin
      lat_pred[i] = '0;
    end
    clear_lattice();

    // Empty lattice, then edges the block must ignore.
    add_directed_row(lattice_item(FUNC_FINISH, 0, 0, '0), 1'b1);
    add_directed_row(lattice_item(FUNC_EDGE, 3, 2, 32'd5), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 63, 63, 32'hFFFF_FFFF), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 7, 0, 32'd1), 1'b0);
    add_directed_row(lattice_item(FUNC_FINISH, 63, 63, 32'hFFFF_FFFF), 1'b1);
    // Top node reached by a heavy edge, then improved by a zero-weight one.
    add_directed_row(lattice_item(FUNC_EDGE, 0, 63, 32'hFFFF_FFFF), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 0, 63, 32'd0), 1'b0);
    add_directed_row(lattice_item(FUNC_FINISH, 0, 0, '0), 1'b0);
    // Edge out of a node nobody reaches.
    add_directed_row(lattice_item(FUNC_EDGE, 5, 9, 32'd1), 1'b0);
    add_directed_row(lattice_item(FUNC_FINISH, 0, 0, '0), 1'b0);
    // Every edge into node 3 ties; the first one must win.
    add_directed_row(lattice_item(FUNC_EDGE, 0, 1, 32'd10), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 0, 2, 32'd4), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 0, 3, 32'd20), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 1, 3, 32'd10), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 2, 3, 32'd16), 1'b0);
    add_directed_row(lattice_item(FUNC_FINISH, 0, 0, '0), 1'b0);
    // Targets out of order, then a long weighted tail up to node 63.
    add_directed_row(lattice_item(FUNC_EDGE, 0, 10, 32'd100), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 0, 4, 32'd3), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 4, 10, 32'd7), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 10, 62, 32'hFFFF_FFFF), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 62, 63, 32'h8000_0000), 1'b0);
    add_directed_row(lattice_item(FUNC_FINISH, 0, 0, '0), 1'b0);
    // Alternating bit patterns on nodes and weights.
    add_directed_row(lattice_item(FUNC_EDGE, 0, 21, 32'h5555_5555), 1'b0);
    add_directed_row(lattice_item(FUNC_EDGE, 21, 42, 32'hAAAA_AAAA), 1'b0);
    add_directed_row(lattice_item(FUNC_FINISH, 42, 21, 32'h5A5A_A5A5), 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_lattice_item(directed_rows[i].item, directed_rows[i].lone_origin);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
          // A full-length path, emitted against a slow receiver.
          run_sentence(MAX_NODES_DEF, 1'b1);
        end
        default: begin
          send_idle_pct  = 19;
          recv_stall_pct = 19;
        end
      endcase
      while (lattice_items < directed_rows.size() + PHASE_QUOTA * (phase + 1)) begin
        run_sentence(($urandom_range(7) == 0) ? $urandom_range(12, 64)
                                              : $urandom_range(1, 10), 1'b0);
      end
      // Hold the sender until every path of this phase is out.
      in_chan.valid <= 1'b0;
      while (expected_path_q.size() != 0) @(posedge clk);
      @(posedge clk);
    end

    repeat (400) @(posedge clk);
    if (mismatch_count == 0 && expected_path_q.size() == 0) begin
      $display("PASS dag_shortest_path_backtrack_core");
    end else begin
      $display("FAIL dag_shortest_path_backtrack_core");
    end
    $finish;
  end

endmodule
